### src/evsp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the stacked VLAN tag parser.
package evsp_pkg;

	localparam int MAX_TAGS = 10;

	localparam int IDX_W  = 8;
	localparam int TYPE_W = 16;
	localparam int VID_W  = 12;
	localparam int CNT_W  = 4;
	localparam int HDR_W  = 6;
	localparam int CFG_W  = 12;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_TDATA_W = 32;

	localparam logic [IDX_W-1:0]  INDEX_CAP   = 8'd255;
	localparam logic [IDX_W-1:0]  POS_HI_TYPE = 8'd12;
	localparam logic [IDX_W-1:0]  POS_LO_TYPE = 8'd13;
	localparam logic [IDX_W-1:0]  ETH_HDR_LEN = 8'd14;
	localparam logic [HDR_W-1:0]  HDR_BASE    = 6'd14;
	localparam logic [TYPE_W-1:0] TPID_CTAG   = 16'h8100;
	localparam logic [TYPE_W-1:0] TPID_STAG   = 16'h88A8;
	localparam logic [CNT_W-1:0]  TAG_LIMIT   = CNT_W'(MAX_TAGS);

	// position inside a 4-byte tag
	localparam logic [1:0] OFF_TCI_HI  = 2'd0;
	localparam logic [1:0] OFF_TCI_LO  = 2'd1;
	localparam logic [1:0] OFF_TYPE_HI = 2'd2;
	localparam logic [1:0] OFF_TYPE_LO = 2'd3;

	typedef enum logic [1:0] {
		VERDICT_PASS  = 2'd0,
		VERDICT_SHORT = 2'd1,
		VERDICT_VID   = 2'd2
	} verdict_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MATCH_VID    = 2'd0,
		REG_MATCH_DEPTH  = 2'd1,
		REG_MATCH_ENABLE = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [VID_W-1:0] match_vid;
		logic [CNT_W-1:0] match_depth;
		logic             match_enable;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] frame_byte;
		logic       end_of_frame;
	} in_item_t;

	typedef struct packed {
		verdict_t          verdict;
		logic [TYPE_W-1:0] final_ethertype;
		logic [CNT_W-1:0]  tags_found;
		logic [HDR_W-1:0]  header_bytes;
	} result_t;

	function automatic logic is_tpid(input logic [TYPE_W-1:0] t);
		return (t == TPID_CTAG) || (t == TPID_STAG);
	endfunction

endpackage

### src/evsp_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration registers of the VLAN tag parser.
module evsp_cfg_regs import evsp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.match_vid    <= 12'd42;
			cfg_q.match_depth  <= 4'd1;
			cfg_q.match_enable <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MATCH_VID:    cfg_q.match_vid    <= cfg_wdata[VID_W-1:0];
				REG_MATCH_DEPTH:  cfg_q.match_depth  <= cfg_wdata[CNT_W-1:0];
				REG_MATCH_ENABLE: cfg_q.match_enable <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/evsp_in_reg.sv
`timescale 1ns / 1ps
// Input register stage of the VLAN tag parser.
module evsp_in_reg import evsp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  logic [7:0] s_tdata,
	input  logic     s_tlast,
	input  logic     take,
	output in_item_t item
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;

	// free when empty or when the held byte moves on this cycle
	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eof_s1  <= s_tlast;
		end
	end

	assign item.valid        = valid_s1;
	assign item.frame_byte   = byte_s1;
	assign item.end_of_frame = eof_s1;

endmodule

### src/evsp_walker.sv
`timescale 1ns / 1ps
// Per-frame header and tag walk state, with the result register.
module evsp_walker import evsp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  in_item_t item,
	output logic     take,
	output logic     res_valid,
	input  logic     res_ready,
	output result_t  res
);

	logic [IDX_W-1:0]  idx_q, idx_nx;
	logic [TYPE_W-1:0] type_q, type_nx;
	logic [7:0]        hold_q, hold_nx;
	logic [CNT_W-1:0]  count_q, count_nx;
	logic              done_q, done_nx;
	logic              hit_q, hit_nx;
	logic              pend_q, pend_nx;

	logic              res_valid_q;
	result_t           res_q, res_nx;
	logic              out_free;
	logic              fire;
	logic [1:0]        off;
	logic [VID_W-1:0]  vid;

	assign out_free = !res_valid_q || res_ready;
	// a last byte waits while the previous verdict is still unread
	assign take = !item.end_of_frame || out_free;
	assign fire = item.valid && take;

	assign off = idx_q[1:0] + 2'd2;
	assign vid = {hold_q[3:0], item.frame_byte};

	always_comb begin
		idx_nx   = idx_q;
		type_nx  = type_q;
		hold_nx  = hold_q;
		count_nx = count_q;
		done_nx  = done_q;
		hit_nx   = hit_q;
		pend_nx  = pend_q;

		if (idx_q == POS_HI_TYPE) begin
			hold_nx = item.frame_byte;
		end else if (idx_q == POS_LO_TYPE) begin
			type_nx = {hold_q, item.frame_byte};
			if (!is_tpid(type_nx)) begin
				done_nx = 1'b1;
			end
		end else if (idx_q >= ETH_HDR_LEN && !done_q) begin
			case (off)
				OFF_TCI_HI, OFF_TYPE_HI: hold_nx = item.frame_byte;
				OFF_TCI_LO: begin
					pend_nx = cfg.match_enable && (count_q == cfg.match_depth)
						&& (vid == cfg.match_vid);
				end
				default: begin
					type_nx  = {hold_q, item.frame_byte};
					count_nx = count_q + 1'b1;
					hit_nx   = hit_q || pend_q;
					pend_nx  = 1'b0;
					if (!is_tpid(type_nx) || count_nx >= TAG_LIMIT) begin
						done_nx = 1'b1;
					end
				end
			endcase
		end

		if (idx_q != INDEX_CAP) begin
			idx_nx = idx_q + 1'b1;
		end

		if (idx_nx < ETH_HDR_LEN) begin
			res_nx.verdict         = VERDICT_SHORT;
			res_nx.final_ethertype = '0;
			res_nx.tags_found      = '0;
			res_nx.header_bytes    = '0;
		end else begin
			res_nx.verdict         = hit_nx ? VERDICT_VID : VERDICT_PASS;
			res_nx.final_ethertype = type_nx;
			res_nx.tags_found      = count_nx;
			res_nx.header_bytes    = HDR_BASE + {count_nx, 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			type_q  <= '0;
			hold_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
			hit_q   <= 1'b0;
			pend_q  <= 1'b0;
		end else if (fire) begin
			if (item.end_of_frame) begin
				// clear for the next frame
				idx_q   <= '0;
				type_q  <= '0;
				hold_q  <= '0;
				count_q <= '0;
				done_q  <= 1'b0;
				hit_q   <= 1'b0;
				pend_q  <= 1'b0;
			end else begin
				idx_q   <= idx_nx;
				type_q  <= type_nx;
				hold_q  <= hold_nx;
				count_q <= count_nx;
				done_q  <= done_nx;
				hit_q   <= hit_nx;
				pend_q  <= pend_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= fire && item.end_of_frame;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && item.end_of_frame) begin
			res_q <= res_nx;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

### src/ethernet_vlan_stack_parser.sv
`timescale 1ns / 1ps
// Top level of the stacked VLAN tag parser.
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid / s_tready  s_tdata = frame byte, s_tlast = end of frame
//  m_        out        m_tvalid / m_tready  m_tdata = one verdict per frame
//  cfg_      in         cfg_we               cfg_index, cfg_wdata
//
// One byte is taken every clock; each byte is held in the input register and its
// state update happens as it leaves, when a last byte's verdict is also loaded
// into the result register. A full-rate stream is sustained with m_tready high;
// a last byte waits in the input register only while the previous verdict is unread.
// Reset clears the frame state and loads match_vid 42, match_depth 1, match_enable 1.
module ethernet_vlan_stack_parser import evsp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // [7:0] frame_byte
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [1:0] verdict, [17:2] final_ethertype,
	                                          // [21:18] tags_found, [27:22] header_bytes
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_wdata
);

	cfg_t     cfg;
	in_item_t item;
	logic     take;
	result_t  res;

	evsp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	evsp_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.take     (take),
		.item     (item)
	);

	evsp_walker u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.item      (item),
		.take      (take),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {4'b0000, res.header_bytes, res.tags_found,
		res.final_ethertype, res.verdict};

endmodule

### sim/tb_ethernet_vlan_stack_parser.sv
`timescale 1ns / 1ps
// Self-checking testbench for the stacked VLAN tag parser.
module tb_ethernet_vlan_stack_parser;
	import evsp_pkg::*;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int PRINT_LIMIT   = 30;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_BYTES   = 15;
	localparam int SETTLE_CYCLES = 4;

	typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_HOLD} rx_mode_t;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata   = '0;
	logic                   s_tlast   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]       cfg_wdata = '0;

	ethernet_vlan_stack_parser u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// copy of the match registers, at their reset values
	logic [VID_W-1:0]  cfg_vid    = 12'd42;
	logic [CNT_W-1:0]  cfg_depth  = 4'd1;
	logic              cfg_enable = 1'b1;

	// per-frame parse state
	logic [IDX_W-1:0]  hdr_pos     = '0;
	logic [TYPE_W-1:0] hdr_type    = '0;
	logic [7:0]        hdr_hold    = '0;
	logic [CNT_W-1:0]  hdr_tags    = '0;
	logic              walk_ended  = 1'b0;
	logic              vid_matched = 1'b0;
	logic              vid_armed   = 1'b0;

	result_t           pending_verdicts[$];
	logic [7:0]        frame_q[$];

	int unsigned cycle_count   = 0;
	int unsigned error_count   = 0;
	int unsigned bytes_sent    = 0;
	int unsigned frames_sent   = 0;
	int unsigned short_frames  = 0;
	int unsigned vid_aborts    = 0;
	int unsigned deepest_stack = 0;
	int unsigned verdicts_seen = 0;
	int          burst_left    = 0;

	rx_mode_t    rx_mode = RX_OPEN;
	int          rx_left = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d verdicts outstanding",
				cycle_count, pending_verdicts.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver back-pressure: change to a random pattern for a random run length
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(8, 60);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN:   m_tready <= 1'b1;
			RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_tready <= (rx_left % 4 == 0);
			default:   m_tready <= (rx_left < 3);
		endcase
	end

	task automatic report_mismatch(input string field, input int unsigned got,
			input int unsigned want);
		if (error_count < PRINT_LIMIT)
			$display("[%0t] verdict %0d: %s got 0x%0h, expected 0x%0h",
				$realtime, verdicts_seen, field, got, want);
		error_count++;
	endtask

	// outputs are stable at the falling edge; a transaction seen here completes at the next rise
	always @(negedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_verdicts.size() == 0) begin
				report_mismatch("unexpected transaction", m_tdata, 0);
			end else begin
				want = pending_verdicts.pop_front();
				if (m_tdata[1:0] != want.verdict)
					report_mismatch("verdict", m_tdata[1:0], want.verdict);
				if (m_tdata[17:2] != want.final_ethertype)
					report_mismatch("final_ethertype", m_tdata[17:2], want.final_ethertype);
				if (m_tdata[21:18] != want.tags_found)
					report_mismatch("tags_found", m_tdata[21:18], want.tags_found);
				if (m_tdata[27:22] != want.header_bytes)
					report_mismatch("header_bytes", m_tdata[27:22], want.header_bytes);
			end
			verdicts_seen++;
		end
	end

	// advance the parse state by one accepted byte; queue a verdict on the last one
	task automatic track_header_byte(input logic [7:0] b, input logic last);
		logic [IDX_W-1:0] rel;
		result_t          r;
		rel = hdr_pos - ETH_HDR_LEN;
		if (hdr_pos == POS_HI_TYPE) begin
			hdr_hold = b;
		end else if (hdr_pos == POS_LO_TYPE) begin
			hdr_type = {hdr_hold, b};
			if (hdr_type != TPID_CTAG && hdr_type != TPID_STAG)
				walk_ended = 1'b1;
		end else if (hdr_pos >= ETH_HDR_LEN && !walk_ended) begin
			case (rel[1:0])
				OFF_TCI_HI, OFF_TYPE_HI: hdr_hold = b;
				OFF_TCI_LO: begin
					// hold the match until the tag is complete
					vid_armed = cfg_enable && hdr_tags == cfg_depth &&
						{hdr_hold[3:0], b} == cfg_vid;
				end
				default: begin
					hdr_type = {hdr_hold, b};
					hdr_tags = hdr_tags + 1'b1;
					if (vid_armed)
						vid_matched = 1'b1;
					vid_armed = 1'b0;
					if ((hdr_type != TPID_CTAG && hdr_type != TPID_STAG) || hdr_tags >= MAX_TAGS)
						walk_ended = 1'b1;
				end
			endcase
		end
		if (hdr_pos != INDEX_CAP)
			hdr_pos = hdr_pos + 1'b1;

		if (last) begin
			if (hdr_pos < ETH_HDR_LEN) begin
				r.verdict         = VERDICT_SHORT;
				r.final_ethertype = '0;
				r.tags_found      = '0;
				r.header_bytes    = '0;
				short_frames++;
			end else begin
				r.verdict         = vid_matched ? VERDICT_VID : VERDICT_PASS;
				r.final_ethertype = hdr_type;
				r.tags_found      = hdr_tags;
				r.header_bytes    = HDR_BASE + {hdr_tags, 2'b00};
				if (vid_matched)
					vid_aborts++;
				if (hdr_tags > deepest_stack)
					deepest_stack = hdr_tags;
			end
			pending_verdicts.push_back(r);
			frames_sent++;
			hdr_pos     = '0;
			hdr_type    = '0;
			hdr_hold    = '0;
			hdr_tags    = '0;
			walk_ended  = 1'b0;
			vid_matched = 1'b0;
			vid_armed   = 1'b0;
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		int   gap;
		logic ready_seen;
		gap = 0;
		if (burst_left == 0) begin
			gap        = $urandom_range(0, 6);
			burst_left = $urandom_range(1, 40);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do begin
			@(negedge clk);
			ready_seen = s_tready;
			@(posedge clk);
		end while (!ready_seen);
		track_header_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_frame();
		int i;
		for (i = 0; i < frame_q.size(); i++)
			send_byte(frame_q[i], i == frame_q.size() - 1);
	endtask

	// stop sending, wait for every verdict, then let the pipeline settle
	task automatic hold_idle();
		s_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input logic [VID_W-1:0] vid, input logic [CNT_W-1:0] depth,
			input logic en);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MATCH_VID;
		cfg_wdata <= vid;
		@(posedge clk);
		cfg_index <= REG_MATCH_DEPTH;
		cfg_wdata <= CFG_W'(depth);
		@(posedge clk);
		cfg_index <= REG_MATCH_ENABLE;
		cfg_wdata <= CFG_W'(en);
		@(posedge clk);
		cfg_we     <= 1'b0;
		cfg_vid    = vid;
		cfg_depth  = depth;
		cfg_enable = en;
	endtask

	// random MAC addresses, then the ethertype
	task automatic start_frame(input logic [TYPE_W-1:0] etype);
		frame_q.delete();
		repeat (12) frame_q.push_back(8'($urandom_range(0, 255)));
		frame_q.push_back(etype[15:8]);
		frame_q.push_back(etype[7:0]);
	endtask

	task automatic add_tag(input logic [15:0] tci, input logic [TYPE_W-1:0] next_type);
		frame_q.push_back(tci[15:8]);
		frame_q.push_back(tci[7:0]);
		frame_q.push_back(next_type[15:8]);
		frame_q.push_back(next_type[7:0]);
	endtask

	task automatic add_payload(input int n);
		repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic cut_frame(input int n);
		while (frame_q.size() > n)
			void'(frame_q.pop_back());
	endtask

	function automatic logic [TYPE_W-1:0] tag_tpid();
		return $urandom_range(0, 1) ? TPID_CTAG : TPID_STAG;
	endfunction

	function automatic logic [TYPE_W-1:0] plain_type();
		return $urandom_range(0, 2) == 0 ? 16'h0800 : 16'($urandom_range(0, 65535));
	endfunction

	function automatic logic [VID_W-1:0] pick_vid();
		return $urandom_range(0, 2) == 0 ? cfg_vid : 12'($urandom_range(0, 4095));
	endfunction

	task automatic test_short_frames();
		start_frame(TPID_CTAG);
		cut_frame(1);
		send_frame();
		start_frame(16'h0800);
		cut_frame(12);
		send_frame();
		start_frame(TPID_STAG);
		cut_frame(13);
		send_frame();
	endtask

	task automatic test_untagged_frames();
		start_frame(16'h0800);
		send_frame();
		start_frame(16'h0000);
		add_payload(6);
		send_frame();
		start_frame(16'hFFFF);
		add_payload(2);
		send_frame();
		// near misses of the two TPIDs must not start a walk
		start_frame(16'h8101);
		add_payload(8);
		send_frame();
		start_frame(16'h88A9);
		add_payload(4);
		send_frame();
	endtask

	task automatic test_tag_stacks();
		// matching VID at the outer tag, but the default depth is the second
		start_frame(TPID_CTAG);
		add_tag(16'h002A, 16'h0800);
		send_frame();
		// priority bits set around a matching VID at depth one
		start_frame(TPID_STAG);
		add_tag(16'h0005, TPID_CTAG);
		add_tag(16'hF02A, 16'h86DD);
		add_payload(10);
		send_frame();
		start_frame(TPID_STAG);
		add_tag(16'h002A, TPID_STAG);
		add_tag(16'h0FFF, 16'h0800);
		send_frame();
	endtask

	// second tag carries the matching VID but is cut short, so it is not counted and its match never takes effect
	task automatic test_partial_tags();
		int k;
		for (k = 0; k < 4; k++) begin
			start_frame(TPID_STAG);
			add_tag(16'h0001, TPID_CTAG);
			add_tag(16'h302A, 16'h0800);
			cut_frame(18 + k);
			send_frame();
		end
	endtask

	task automatic test_tag_limit();
		int i;
		start_frame(TPID_CTAG);
		for (i = 0; i < 11; i++)
			add_tag(i == 1 ? 16'h002A : 16'($urandom_range(0, 65535)), tag_tpid());
		add_payload(3);
		send_frame();
	endtask

	// long enough to saturate the byte position
	task automatic test_long_frame();
		start_frame(16'h0800);
		add_payload(286);
		send_frame();
		start_frame(TPID_CTAG);
		add_tag(16'h002A, TPID_CTAG);
		add_tag(16'h002A, 16'h88CC);
		add_payload(270);
		send_frame();
	endtask

	task automatic test_vid_rules();
		int i;
		hold_idle();
		write_config(12'd0, 4'd0, 1'b1);
		start_frame(TPID_CTAG);
		add_tag(16'h0000, TPID_CTAG);
		add_tag(16'h0000, 16'h0800);
		send_frame();
		start_frame(TPID_CTAG);
		add_tag(16'h0001, TPID_CTAG);
		add_tag(16'h0000, 16'h0800);
		send_frame();

		hold_idle();
		write_config(12'hFFF, 4'd9, 1'b1);
		// deepest reachable tag matches
		start_frame(TPID_STAG);
		for (i = 0; i < 10; i++)
			add_tag(16'hFFFF, i < 9 ? TPID_CTAG : 16'h0800);
		send_frame();
		// nine tags: nothing at the compared depth
		start_frame(TPID_STAG);
		for (i = 0; i < 9; i++)
			add_tag(16'hFFFF, i < 8 ? TPID_CTAG : 16'h0800);
		send_frame();
		// tenth tag cut after its TCI
		start_frame(TPID_STAG);
		for (i = 0; i < 10; i++)
			add_tag(16'hFFFF, TPID_CTAG);
		cut_frame(14 + 36 + 2);
		send_frame();

		hold_idle();
		write_config(12'd42, 4'd1, 1'b0);
		start_frame(TPID_CTAG);
		add_tag(16'h0000, TPID_CTAG);
		add_tag(16'h002A, 16'h0800);
		send_frame();

		// depth beyond the tag limit never fires
		hold_idle();
		write_config(12'd42, 4'd15, 1'b1);
		start_frame(TPID_CTAG);
		for (i = 0; i < 11; i++)
			add_tag(16'h002A, TPID_CTAG);
		add_payload(2);
		send_frame();
	endtask

	task automatic random_frame();
		int kind;
		int ntags;
		int i;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			frame_q.delete();
			add_payload($urandom_range(1, 40));
		end else if (kind == 1) begin
			start_frame(16'($urandom_range(0, 65535)));
			cut_frame($urandom_range(1, 13));
		end else begin
			ntags = $urandom_range(0, 3) == 0 ? $urandom_range(4, 11) : $urandom_range(0, 3);
			start_frame(ntags > 0 ? tag_tpid() : plain_type());
			for (i = 0; i < ntags; i++)
				add_tag({4'($urandom_range(0, 15)), pick_vid()},
					i < ntags - 1 ? tag_tpid() : plain_type());
			add_payload($urandom_range(0, 20));
			if ($urandom_range(0, 4) == 0)
				cut_frame($urandom_range(14, frame_q.size()));
		end
		send_frame();
	endtask

	task automatic test_random_traffic();
		int phase;
		int phase_end;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			hold_idle();
			case (phase)
				0: write_config(12'd42, 4'd1, 1'b1);
				1: write_config(12'd0, 4'd0, 1'b1);
				2: write_config(12'hFFF, 4'd9, 1'b1);
				3: write_config(12'($urandom_range(0, 4095)), 4'($urandom_range(0, 9)), 1'b0);
				default: write_config(12'($urandom_range(0, 4095)),
					4'($urandom_range(0, 3)), 1'b1);
			endcase
			phase_end = bytes_sent + PHASE_BYTES;
			while (bytes_sent < phase_end)
				random_frame();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_frames();
		test_untagged_frames();
		test_tag_stacks();
		test_partial_tags();
		test_tag_limit();
		test_long_frame();
		test_vid_rules();
		test_random_traffic();
		hold_idle();
		repeat (10) @(posedge clk);

		$display("Parsed %0d frames from %0d bytes: %0d short, %0d VID aborts, %0d passes.",
			frames_sent, bytes_sent, short_frames, vid_aborts,
			frames_sent - short_frames - vid_aborts);
		$display("Deepest stack %0d tags; %0d verdicts checked, %0d mismatches.",
			deepest_stack, verdicts_seen, error_count);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### filelist.f
src/evsp_pkg.sv
src/evsp_cfg_regs.sv
src/evsp_in_reg.sv
src/evsp_walker.sv
src/ethernet_vlan_stack_parser.sv
sim/tb_ethernet_vlan_stack_parser.sv
